// File: src/lpdt_pkg.sv
// Shared constants and types for the lap period to DAC unit.
// Used by lpdt_div, the top level and the checker. No dependencies.
`default_nettype none

package lpdt_pkg;

	localparam int DAC_BITS  = 12;
	localparam int CODE_W    = DAC_BITS;
	localparam int STAMP_W   = 32;
	localparam int SEC_W     = 16;
	localparam int MS_W      = 10;
	localparam int CNT_W     = 16;
	localparam int TRIM_W    = DAC_BITS + 1;
	localparam int LAPS_W    = 8;
	localparam int LAPCFG_W  = 7;
	localparam int CFG10_W   = 10;
	localparam int DIV_W     = 32;
	localparam int DVSR_W    = 10;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int E_W       = DAC_BITS + 16;
	localparam int SUM_W     = TRIM_W + 2;
	localparam int ADDR_W    = 4;
	localparam int APB_W     = 32;

	localparam logic [CODE_W-1:0] DAC_FULL = '1;
	localparam logic [DVSR_W-1:0] MS_PER_S = DVSR_W'(1000);
	localparam logic [DVSR_W-1:0] MS_FULL  = DVSR_W'(999);
	localparam logic [SEC_W-1:0]  SEC_SAT  = '1;

	localparam logic signed [E_W-1:0] E_CODE_GAIN = E_W'(5000);
	localparam logic signed [E_W-1:0] E_CNT_GAIN  = E_W'(3 << (DAC_BITS - 4));
	localparam logic signed [E_W-1:0] E_TOL_GAIN  = E_W'(3 << (DAC_BITS - 5));

	localparam logic signed [TRIM_W-1:0] TRIM_MAX = {1'b0, {(TRIM_W-1){1'b1}}};
	localparam logic signed [TRIM_W-1:0] TRIM_MIN = {1'b1, {(TRIM_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_LAP_COUNT   = 2'd0,
		REG_MAX_SECONDS = 2'd1,
		REG_TOLERANCE   = 2'd2,
		REG_DAC_OFFSET  = 2'd3
	} lpdt_reg_t;

	typedef enum logic {
		OP_PULSE    = 1'b0,
		OP_READBACK = 1'b1
	} lpdt_op_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
	} lpdt_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quot;
		logic [DVSR_W-1:0] rem;
	} lpdt_div_rsp_t;

	typedef struct packed {
		logic signed [TRIM_W-1:0] trim;
		logic                     flag;
	} lpdt_adj_t;

endpackage

`default_nettype wire

// File: src/lpdt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, narrow divisor.
// Depends on lpdt_pkg for widths and the request and response types.
`default_nettype none

module lpdt_div
	import lpdt_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  lpdt_div_req_t req,
	output lpdt_div_rsp_t rsp
);

	logic [DIV_W-1:0]     quo_q;
	logic [DVSR_W-1:0]    rem_q;
	logic [DVSR_W-1:0]    dvsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DVSR_W:0]   trial;
	logic              ge;
	logic [DVSR_W-1:0] rem_nx;

	assign trial  = {rem_q, quo_q[DIV_W-1]};
	assign ge     = trial >= {1'b0, dvsr_q};
	assign rem_nx = ge ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// File: src/lap_period_to_dac_with_trim_unit.sv
// Lap period timer with trimmed DAC codes: top level, registers and control.
// Depends on lpdt_pkg and two instances of the serial divider lpdt_div.
//
// Usage: items enter on the s_axis channel. s_axis_tuser selects a pulse
// (stamp in s_axis_tdata) or a converter readback (two counts in tdata).
// Every item gives exactly one result on m_axis: the held period, both
// trimmed DAC codes, a period-done flag and a readback request flag.
// Write the registers over the APB port only while no item is in flight;
// the block itself does not enforce this. One item is worked on at a time,
// and the next item is taken only once the last one has left the final
// state. The time is spent in the bit-serial divider: 32 steps for seconds
// and milliseconds of the period when a pulse completes it, then 32 steps
// for both scaled codes at once.
// s_axis_tready is high only while no item is in work. The result sits in an
// output register, so a new item is taken while it waits; if the receiver
// stalls, the next result waits in the final state until the register frees.
// Reset clears the period state, the trims and the flags and loads the
// register defaults; the block is ready in the first cycle after reset.
`default_nettype none

module lap_period_to_dac_with_trim_unit
	import lpdt_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	// stamp_ms [31:0], readback_seconds [47:32], readback_millis [63:48]
	input  wire  [63:0]       s_axis_tdata,
	// opcode [0]
	input  wire  [0:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	// seconds [15:0], millis [25:16], code_seconds [37:26],
	// code_millis [49:38], period_done [50], need_readback [51], zero [55:52]
	output logic [55:0]       m_axis_tdata,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [ADDR_W-1:0] paddr,
	input  wire  [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_PULSE  = 8'b0000_0010,
		ST_DIVP   = 8'b0000_0100,
		ST_SSTART = 8'b0000_1000,
		ST_SCALE  = 8'b0001_0000,
		ST_ADJE   = 8'b0010_0000,
		ST_ADJU   = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [LAPCFG_W-1:0]     lap_count_q;
	logic [CFG10_W-1:0]      max_seconds_q;
	logic [CFG10_W-1:0]      tolerance_q;
	logic signed [CODE_W-1:0] dac_offset_q;

	logic                    in_op_q;
	logic [STAMP_W-1:0]      in_stamp_q;
	logic signed [CNT_W-1:0] in_rbs_q;
	logic signed [CNT_W-1:0] in_rbm_q;

	logic [STAMP_W-1:0]       last_stamp_q;
	logic [STAMP_W-1:0]       gap_sum_q;
	logic [LAPS_W-1:0]        laps_q;
	logic [SEC_W-1:0]         held_s_q;
	logic [MS_W-1:0]          held_m_q;
	logic signed [TRIM_W-1:0] trim_s_q;
	logic signed [TRIM_W-1:0] trim_m_q;
	logic [1:0]               flags_q;
	logic                     done_q;

	logic [CODE_W-1:0]     base_s_q;
	logic [CODE_W-1:0]     base_m_q;
	logic signed [E_W-1:0] e_s_q;
	logic signed [E_W-1:0] e_m_q;
	logic signed [E_W-1:0] t_q;

	logic [55:0] m_tdata_q;
	logic        m_tvalid_q;

	lpdt_div_req_t div_s_req;
	lpdt_div_req_t div_m_req;
	lpdt_div_rsp_t div_s_rsp;
	lpdt_div_rsp_t div_m_rsp;

	logic                cfg_wr;
	lpdt_reg_t           reg_sel;
	logic                s_acc;
	logic                pulse_hit;
	logic [STAMP_W-1:0]  gap;
	logic [STAMP_W-1:0]  gap_sum_nx;
	logic [LAPS_W-1:0]   laps_nx;
	logic                period_end;
	logic [CODE_W-1:0]   scale_s;
	logic [CODE_W-1:0]   scale_m;
	logic [CODE_W-1:0]   code_s;
	logic [CODE_W-1:0]   code_m;
	logic                out_free;
	lpdt_adj_t           adj_s;
	lpdt_adj_t           adj_m;

	function automatic lpdt_adj_t adj_step(input logic signed [E_W-1:0] e,
			input logic signed [E_W-1:0] t, input lpdt_adj_t cur);
		lpdt_adj_t nx;
		nx = cur;
		if (e > 0 && e > t) begin
			if (cur.trim != TRIM_MAX)
				nx.trim = cur.trim + TRIM_W'(1);
			nx.flag = 1'b1;
		end else if (e > 0) begin
			nx.flag = 1'b0;
		end else if (e < 0 && e < -t) begin
			if (cur.trim != TRIM_MIN)
				nx.trim = cur.trim - TRIM_W'(1);
			nx.flag = 1'b1;
		end else if (e < 0 && e > -t) begin
			nx.flag = 1'b0;
		end
		return nx;
	endfunction

	function automatic logic [CODE_W-1:0] trim_code(input logic [CODE_W-1:0] base,
			input logic signed [CODE_W-1:0] ofs, input logic signed [TRIM_W-1:0] trim);
		logic signed [SUM_W-1:0] sum;
		sum = signed'(SUM_W'(base)) + SUM_W'(ofs) + SUM_W'(trim);
		if (sum < 0)
			return '0;
		else if (sum > signed'(SUM_W'(DAC_FULL)))
			return DAC_FULL;
		else
			return sum[CODE_W-1:0];
	endfunction

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_sel = lpdt_reg_t'(paddr[ADDR_W-1:2]);

	always_comb begin
		case (reg_sel)
			REG_LAP_COUNT:   prdata = APB_W'(lap_count_q);
			REG_MAX_SECONDS: prdata = APB_W'(max_seconds_q);
			REG_TOLERANCE:   prdata = APB_W'(tolerance_q);
			REG_DAC_OFFSET:  prdata = APB_W'(unsigned'(dac_offset_q));
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lap_count_q   <= LAPCFG_W'(1);
			max_seconds_q <= CFG10_W'(600);
			tolerance_q   <= CFG10_W'(16);
			dac_offset_q  <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_LAP_COUNT:   lap_count_q   <= pwdata[LAPCFG_W-1:0];
				REG_MAX_SECONDS: max_seconds_q <= pwdata[CFG10_W-1:0];
				REG_TOLERANCE:   tolerance_q   <= pwdata[CFG10_W-1:0];
				REG_DAC_OFFSET:  dac_offset_q  <= signed'(pwdata[CODE_W-1:0]);
				default: ;
			endcase
		end
	end

	// Pulse bookkeeping.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid & s_axis_tready;
	assign pulse_hit     = (in_op_q == OP_PULSE) && (in_stamp_q != last_stamp_q);
	assign gap           = (last_stamp_q == '0) ? '0 : in_stamp_q - last_stamp_q;
	assign gap_sum_nx    = gap_sum_q + gap;
	assign laps_nx       = laps_q + LAPS_W'(1);
	assign period_end    = pulse_hit && (laps_nx > LAPS_W'(lap_count_q));

	// The seconds divider first splits a finished period, then scales seconds.
	always_comb begin
		div_s_req.start    = (state_q == ST_PULSE && period_end) || (state_q == ST_SSTART);
		div_s_req.dividend = gap_sum_nx;
		div_s_req.divisor  = MS_PER_S;
		if (state_q == ST_SSTART) begin
			div_s_req.dividend = DIV_W'({held_s_q, {CODE_W{1'b0}}}) - DIV_W'(held_s_q);
			div_s_req.divisor  = max_seconds_q;
		end
		div_m_req.start    = (state_q == ST_SSTART);
		div_m_req.dividend = DIV_W'({held_m_q, {CODE_W{1'b0}}}) - DIV_W'(held_m_q);
		div_m_req.divisor  = MS_FULL;
	end

	lpdt_div u_div_s (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_s_req),
		.rsp    (div_s_rsp)
	);

	lpdt_div u_div_m (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_m_req),
		.rsp    (div_m_rsp)
	);

	assign scale_s = (max_seconds_q == '0) ? DAC_FULL :
		(div_s_rsp.quot > DIV_W'(DAC_FULL)) ? DAC_FULL : div_s_rsp.quot[CODE_W-1:0];
	assign scale_m = (div_m_rsp.quot > DIV_W'(DAC_FULL)) ? DAC_FULL :
		div_m_rsp.quot[CODE_W-1:0];

	assign adj_s = adj_step(e_s_q, t_q, '{trim: trim_s_q, flag: flags_q[0]});
	assign adj_m = adj_step(e_m_q, t_q, '{trim: trim_m_q, flag: flags_q[1]});

	assign code_s   = trim_code(base_s_q, dac_offset_q, trim_s_q);
	assign code_m   = trim_code(base_m_q, dac_offset_q, trim_m_q);
	assign out_free = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_stamp_q <= '0;
			gap_sum_q    <= '0;
			laps_q       <= '0;
			held_s_q     <= '0;
			held_m_q     <= '0;
			trim_s_q     <= '0;
			trim_m_q     <= '0;
			flags_q      <= '0;
			done_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_axis_tready && state_q != ST_FINISH)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						done_q  <= 1'b0;
						state_q <= ST_PULSE;
					end
				end
				ST_PULSE: begin
					if (period_end)
						state_q <= ST_DIVP;
					else
						state_q <= ST_SSTART;
					if (pulse_hit) begin
						last_stamp_q <= in_stamp_q;
						if (period_end) begin
							gap_sum_q <= '0;
							laps_q    <= LAPS_W'(1);
							flags_q   <= 2'b11;
							done_q    <= 1'b1;
						end else begin
							gap_sum_q <= gap_sum_nx;
							laps_q    <= laps_nx;
						end
					end
				end
				ST_DIVP: begin
					if (div_s_rsp.done) begin
						held_s_q <= (div_s_rsp.quot[DIV_W-1:SEC_W] != '0) ? SEC_SAT :
							div_s_rsp.quot[SEC_W-1:0];
						held_m_q <= div_s_rsp.rem;
						state_q  <= ST_SSTART;
					end
				end
				ST_SSTART: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (div_s_rsp.done)
						state_q <= ST_ADJE;
				end
				ST_ADJE: begin
					state_q <= ST_ADJU;
				end
				ST_ADJU: begin
					if (in_op_q == OP_READBACK && flags_q != '0) begin
						trim_s_q <= adj_s.trim;
						trim_m_q <= adj_m.trim;
						flags_q  <= {adj_m.flag, adj_s.flag};
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			in_op_q    <= s_axis_tuser[0];
			in_stamp_q <= s_axis_tdata[31:0];
			in_rbs_q   <= signed'(s_axis_tdata[47:32]);
			in_rbm_q   <= signed'(s_axis_tdata[63:48]);
		end
		if (state_q == ST_SCALE && div_s_rsp.done) begin
			base_s_q <= scale_s;
			base_m_q <= scale_m;
		end
		if (state_q == ST_ADJE) begin
			e_s_q <= signed'(E_W'(base_s_q)) * E_CODE_GAIN - E_W'(in_rbs_q) * E_CNT_GAIN;
			e_m_q <= signed'(E_W'(base_m_q)) * E_CODE_GAIN - E_W'(in_rbm_q) * E_CNT_GAIN;
			t_q   <= signed'(E_W'(tolerance_q)) * E_TOL_GAIN;
		end
		if (state_q == ST_FINISH && out_free)
			m_tdata_q <= {4'b0000, (flags_q != '0), done_q, code_m, code_s,
				held_m_q, held_s_q};
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// File: src/lpdt_checker.sv
// Port-level checks for the lap period to DAC unit, bound to the top level.
// Depends on lpdt_pkg for widths; sees only the top-level ports.
`default_nettype none

module lpdt_checker
	import lpdt_pkg::*;
(
	input wire              clk,
	input wire              arst_n,
	input wire              s_axis_tvalid,
	input wire              s_axis_tready,
	input wire [63:0]       s_axis_tdata,
	input wire [0:0]        s_axis_tuser,
	input wire              m_axis_tvalid,
	input wire              m_axis_tready,
	input wire [55:0]       m_axis_tdata,
	input wire              psel,
	input wire              penable,
	input wire              pwrite,
	input wire [ADDR_W-1:0] paddr,
	input wire [APB_W-1:0]  pwdata,
	input wire [APB_W-1:0]  prdata,
	input wire              pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in work");

	a_millis_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[25:16] <= MS_W'(999))
		else $error("millisecond remainder out of range");

	a_done_arms: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tdata[51])
		else $error("completed period without readback request");

endmodule

bind lap_period_to_dac_with_trim_unit lpdt_checker u_lpdt_checker (.*);

`default_nettype wire

// File: sim/lpdt_period_checker.sv
`timescale 1ns / 1ps
// Result checker for the lap period to DAC unit: follows register writes and
// both item channels, predicts every result and compares it field by field.
// Depends on lpdt_pkg for widths, register indexes and operation codes.
module lpdt_period_checker
	import lpdt_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	input  wire              s_axis_tready,
	// stamp_ms [31:0], readback_seconds [47:32], readback_millis [63:48]
	input  wire [63:0]       s_axis_tdata,
	// opcode [0]
	input  wire [0:0]        s_axis_tuser,
	input  wire              m_axis_tvalid,
	input  wire              m_axis_tready,
	// seconds [15:0], millis [25:16], code_seconds [37:26],
	// code_millis [49:38], period_done [50], need_readback [51], zero [55:52]
	input  wire [55:0]       m_axis_tdata,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire              pready,
	input  wire [ADDR_W-1:0] paddr,
	input  wire [APB_W-1:0]  pwdata,
	output int               errors,
	output int               pending,
	output int               checked
);

	localparam longint CODE_TOP = (longint'(1) << DAC_BITS) - 1;
	localparam longint ERR_CODE_GAIN = 5000;
	localparam longint ERR_COUNT_GAIN = 3 << (DAC_BITS - 4);
	localparam longint ERR_TOL_GAIN = 3 << (DAC_BITS - 5);

	typedef struct packed {
		logic [3:0]        pad;
		logic              need;
		logic              done;
		logic [CODE_W-1:0] code_ms;
		logic [CODE_W-1:0] code_sec;
		logic [MS_W-1:0]   millis;
		logic [SEC_W-1:0]  seconds;
	} period_result_t;

	logic [LAPCFG_W-1:0]      lap_count;
	logic [CFG10_W-1:0]       max_seconds;
	logic [CFG10_W-1:0]       tolerance;
	logic signed [CODE_W-1:0] dac_offset;

	logic [STAMP_W-1:0]       last_stamp;
	logic [STAMP_W-1:0]       gap_sum;
	logic [LAPS_W-1:0]        laps_seen;
	logic [SEC_W-1:0]         held_sec;
	logic [MS_W-1:0]          held_ms;
	logic signed [TRIM_W-1:0] trim_sec;
	logic signed [TRIM_W-1:0] trim_ms;
	logic                     armed_sec;
	logic                     armed_ms;

	period_result_t due_results[$];

	function automatic longint scale_to_code(input longint v, input longint full_at);
		longint r;
		if (full_at == 0)
			return CODE_TOP;
		r = v * CODE_TOP / full_at;
		return (r > CODE_TOP) ? CODE_TOP : r;
	endfunction

	function automatic logic [CODE_W-1:0] trimmed_code(input longint base,
			input logic signed [TRIM_W-1:0] trim);
		longint c;
		c = base + longint'(dac_offset) + longint'(trim);
		if (c < 0)
			c = 0;
		if (c > CODE_TOP)
			c = CODE_TOP;
		return c[CODE_W-1:0];
	endfunction

	// A zero error, or one sitting exactly on the negative band edge, leaves
	// both the trim and the flag alone.
	task automatic nudge_trim(input longint code, input logic [CNT_W-1:0] count,
			inout logic signed [TRIM_W-1:0] trim, inout logic armed);
		longint err;
		longint band;
		err = ERR_CODE_GAIN * code - ERR_COUNT_GAIN * longint'($signed(count));
		band = ERR_TOL_GAIN * longint'(tolerance);
		if (err > 0 && err > band) begin
			if (trim != TRIM_MAX)
				trim = trim + TRIM_W'(1);
			armed = 1'b1;
		end else if (err > 0) begin
			armed = 1'b0;
		end else if (err < 0 && err < -band) begin
			if (trim != TRIM_MIN)
				trim = trim - TRIM_W'(1);
			armed = 1'b1;
		end else if (err < 0 && err > -band) begin
			armed = 1'b0;
		end
	endtask

	task automatic predict_item(input lpdt_op_t op, input logic [63:0] data);
		period_result_t r;
		longint base_sec;
		longint base_ms;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] whole_sec;
		r = '0;
		stamp = data[STAMP_W-1:0];
		if (op == OP_PULSE && stamp != last_stamp) begin
			if (last_stamp == 0)
				last_stamp = stamp;
			gap_sum = gap_sum + (stamp - last_stamp);
			last_stamp = stamp;
			laps_seen = laps_seen + 1'b1;
			if (laps_seen > lap_count) begin
				whole_sec = gap_sum / MS_PER_S;
				held_sec = (whole_sec > SEC_SAT) ? SEC_SAT : whole_sec[SEC_W-1:0];
				held_ms = MS_W'(gap_sum % MS_PER_S);
				gap_sum = '0;
				laps_seen = LAPS_W'(1);
				armed_sec = 1'b1;
				armed_ms = 1'b1;
				r.done = 1'b1;
			end
		end
		base_sec = scale_to_code(longint'(held_sec), longint'(max_seconds));
		base_ms = scale_to_code(longint'(held_ms), longint'(MS_FULL));
		if (op == OP_READBACK && (armed_sec || armed_ms)) begin
			nudge_trim(base_sec, data[47:32], trim_sec, armed_sec);
			nudge_trim(base_ms, data[63:48], trim_ms, armed_ms);
		end
		r.seconds = held_sec;
		r.millis = held_ms;
		r.code_sec = trimmed_code(base_sec, trim_sec);
		r.code_ms = trimmed_code(base_ms, trim_ms);
		r.need = armed_sec || armed_ms;
		due_results.push_back(r);
	endtask

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t ns: result %0d, %s expected %0d, got %0d",
				$time, checked, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		period_result_t want;
		period_result_t got;
		if (!arst_n) begin
			lap_count = LAPCFG_W'(1);
			max_seconds = CFG10_W'(600);
			tolerance = CFG10_W'(16);
			dac_offset = '0;
			last_stamp = '0;
			gap_sum = '0;
			laps_seen = '0;
			held_sec = '0;
			held_ms = '0;
			trim_sec = '0;
			trim_ms = '0;
			armed_sec = 1'b0;
			armed_ms = 1'b0;
			due_results.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (lpdt_reg_t'(paddr[ADDR_W-1:2]))
					REG_LAP_COUNT:   lap_count = pwdata[LAPCFG_W-1:0];
					REG_MAX_SECONDS: max_seconds = pwdata[CFG10_W-1:0];
					REG_TOLERANCE:   tolerance = pwdata[CFG10_W-1:0];
					REG_DAC_OFFSET:  dac_offset = pwdata[CODE_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = period_result_t'(m_axis_tdata);
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t ns: result %h arrived with nothing expected",
						$time, m_axis_tdata);
				end else begin
					want = due_results.pop_front();
					check_field("seconds", want.seconds, got.seconds);
					check_field("millis", want.millis, got.millis);
					check_field("code_seconds", want.code_sec, got.code_sec);
					check_field("code_millis", want.code_ms, got.code_ms);
					check_field("period_done", want.done, got.done);
					check_field("need_readback", want.need, got.need);
					check_field("padding", want.pad, got.pad);
				end
				checked++;
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_item(lpdt_op_t'(s_axis_tuser[0]), s_axis_tdata);
			pending = due_results.size();
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the lap period to DAC unit: clock, reset, register setup,
// item stimulus with random idling on both channels, and the verdict.
// Depends on lpdt_pkg, the block and lpdt_period_checker, which does the checking.
module tb_top;
	import lpdt_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS = 370;
	localparam int BURST_ITEMS = 60;
	localparam int DONE_BIT = SEC_W + MS_W + 2 * CODE_W;
	localparam longint CODE_TOP = (longint'(1) << DAC_BITS) - 1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [63:0]       s_axis_tdata = '0;
	logic [0:0]        s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [55:0]       m_axis_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0]  pwdata = '0;
	logic [APB_W-1:0]  prdata;
	logic              pready;

	int errors;
	int pending;
	int checked;

	bit               no_idle = 1'b0;
	int               stall_left = 0;
	int               quiet_cycles = 0;
	int               pulses = 0;
	int               readbacks = 0;
	int               periods = 0;
	int               burst_items = 0;
	int               cfg_max = 600;
	int               cfg_tol = 16;
	logic [31:0]      stamp_now = '0;
	logic [SEC_W-1:0] seen_sec = '0;
	logic [MS_W-1:0]  seen_ms = '0;
	logic             seen_need = 1'b0;

	always #4 clk = ~clk;

	lap_period_to_dac_with_trim_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	lpdt_period_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 100);
	endfunction

	function automatic logic [31:0] next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3000);
		if (r < 95)
			return $urandom_range(3000, 400000);
		return $urandom_range(1, 20);
	endfunction

	function automatic longint aim_base(input longint v, input longint full_at);
		longint r;
		if (full_at == 0)
			return CODE_TOP;
		r = v * CODE_TOP / full_at;
		return (r > CODE_TOP) ? CODE_TOP : r;
	endfunction

	// Aims the readback count near the ideal one, mostly inside or just
	// around the trim deadband, where one count is two tolerance steps.
	function automatic logic [15:0] aim_count(input longint code);
		longint c;
		int r;
		int sgn;
		c = code * 5000 / (3 << (DAC_BITS - 4));
		r = $urandom_range(0, 99);
		sgn = $urandom_range(0, 1) ? 1 : -1;
		if (r < 15)
			c = c;
		else if (r < 55)
			c = c + sgn * int'($urandom_range(0, cfg_tol / 2 + 1));
		else if (r < 80)
			c = c + sgn * int'($urandom_range(0, 3));
		else if (r < 95)
			c = c + sgn * int'($urandom_range(0, 64));
		else
			c = sgn > 0 ? 32767 : -32768;
		if (c > 32767)
			c = 32767;
		if (c < -32768)
			c = -32768;
		return c[15:0];
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			seen_sec <= m_axis_tdata[SEC_W-1:0];
			seen_ms <= m_axis_tdata[SEC_W+MS_W-1:SEC_W];
			seen_need <= m_axis_tdata[DONE_BIT+1];
			if (m_axis_tdata[DONE_BIT])
				periods <= periods + 1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				m_axis_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	task automatic send_item(input lpdt_op_t op, input logic [63:0] data);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (op == OP_PULSE)
			pulses++;
		else
			readbacks++;
		if (no_idle)
			burst_items++;
	endtask

	task automatic send_pulse(input logic [31:0] stamp);
		send_item(OP_PULSE, {$urandom(), stamp});
		stamp_now = stamp;
	endtask

	task automatic send_readback(input logic [15:0] count_sec, input logic [15:0] count_ms);
		send_item(OP_READBACK, {count_ms, count_sec, $urandom()});
	endtask

	task automatic apb_write(input lpdt_reg_t idx, input logic [APB_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_config(input int lap, input int max_s, input int tol, input int off);
		drain();
		apb_write(REG_LAP_COUNT, APB_W'(lap));
		apb_write(REG_MAX_SECONDS, APB_W'(max_s));
		apb_write(REG_TOLERANCE, APB_W'(tol));
		apb_write(REG_DAC_OFFSET, APB_W'(off & 'hFFF));
		cfg_max = max_s;
		cfg_tol = tol;
	endtask

	// Mostly advancing pulses and readbacks aimed at the trim loop, with a
	// share of repeated, wrapped, zero and random stamps and random counts.
	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (!seen_need && r >= 55 && r < 85 && $urandom_range(0, 3) != 0)
			r = 0;
		if (r < 55)
			send_pulse(stamp_now + next_gap());
		else if (r < 85)
			send_readback(aim_count(aim_base(longint'(seen_sec), cfg_max)),
				aim_count(aim_base(longint'(seen_ms), longint'(MS_FULL))));
		else if (r < 92)
			send_readback(16'($urandom()), 16'($urandom()));
		else if (r < 95)
			send_pulse(stamp_now);
		else if (r < 97)
			send_pulse($urandom());
		else if (r < 98)
			send_pulse('0);
		else
			send_pulse(stamp_now + $urandom_range(60000000, 300000000));
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every pulse with a new stamp closes a period here, and the band edge is one count.
		set_config(0, 600, 2, 0);
		send_readback(16'h8000, 16'h7FFF);
		send_pulse(32'd0);
		send_pulse(32'd1000);
		send_readback(16'd0, 16'd0);
		send_readback(16'd1, 16'd1);
		send_readback(16'd2, 16'd2);
		send_pulse(32'd2234);
		send_readback(16'd30, 16'd6250);
		send_readback(16'd39, 16'd6244);
		send_readback(16'h7FFF, 16'h8000);
		send_pulse(32'hFFFF_FFF0);
		send_readback(16'h8000, 16'h7FFF);
		send_pulse(32'h0000_0010);
		send_pulse(32'h0000_0010);
		send_pulse(32'd0);
		send_pulse(32'd5);
		send_readback(16'h7FFF, 16'h8000);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_config(1, 600, 16, 0);
				1: set_config(0, 0, 0, -2048);
				2: set_config(99, 999, 999, 2047);
				3: set_config(2, 1, 1, -37);
				default: set_config($urandom_range(1, 8), $urandom_range(1, 999),
					$urandom_range(0, 60), int'($urandom_range(0, 600)) - 300);
			endcase
			no_idle = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == BURST_ITEMS)
					no_idle = 1'b0;
				random_item();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d pulse and %0d readback items over six register settings,",
			pulses, readbacks);
		$display("%0d of them back to back; %0d results compared, %0d closing a period.",
			burst_items, checked, periods);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
